/* src/nhe_pkg.sv */
// Shared types and constants for the nucleotide Huffman encoder.
`default_nettype none

package nhe_pkg;

    // Kind of work carried from the front to the back.
    localparam logic [1:0] KIND_SYM   = 2'd0;
    localparam logic [1:0] KIND_BAD   = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_BITS_A = 3'd0;
    localparam logic [2:0] REG_LEN_A  = 3'd1;
    localparam logic [2:0] REG_BITS_C = 3'd2;
    localparam logic [2:0] REG_LEN_C  = 3'd3;
    localparam logic [2:0] REG_BITS_G = 3'd4;
    localparam logic [2:0] REG_LEN_G  = 3'd5;
    localparam logic [2:0] REG_BITS_T = 3'd6;
    localparam logic [2:0] REG_LEN_T  = 3'd7;

    // Input request types.
    localparam logic REQ_SYMBOL = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] len;
        logic [2:0] code;
    } nhe_item_t;

endpackage

`default_nettype wire

/* src/nucleotide_huffman_encoder.sv */
// Top level of the nucleotide Huffman encoder with bit packer.
//
//  Channel  Direction  Payload                                     Handshake
//  s_       in         tdata[7:0] symbol_char, tuser[0] req_type   tvalid/tready
//  m_       out        tdata[7:0] out_byte, tlast is_last,         tvalid/tready
//                      tuser[0] bad_symbol
//  cfg_     in         index 0..7, wdata[2:0]                      write enable
//
// The back end handles a symbol or a bad character at once, so one beat can be
// accepted every cycle while the output is taken. A flush with bits pending gives
// a padded byte, then a trailer; the output register is the limit.
// An accepted beat is registered in the queue and then in the output register on the m_ side.
// Reset is synchronous and active low; it restores the default codes (two bits
// each, A=00 C=01 G=10 T=11) and empties the accumulator and the queue.
// A stall on m_ holds the result; the two-entry queue keeps s_ open until it is full.
`default_nettype none

module nucleotide_huffman_encoder
    import nhe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Configuration write port.
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [2:0] cfg_wdata,
    // Input stream.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol_char
    input  wire logic       s_tuser,   // [0] req_type
    // Output stream.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // is_last
    output logic            m_tuser    // [0] bad_symbol
);

    nhe_item_t front_item;
    nhe_item_t q_item;
    logic      q_not_full;
    logic      q_not_empty;
    logic      q_pop;

    // The front classifies the character and looks up its code in the same cycle
    // as the beat is accepted.
    nhe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req_type    (s_tuser),
        .symbol_char (s_tdata),
        .item        (front_item)
    );

    assign s_tready = q_not_full;

    nhe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    // The back owns the accumulator and the output register.
    nhe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_bad   (m_tuser)
    );

endmodule

`default_nettype wire

/* src/nhe_front.sv */
// Front end: configuration registers, character classification and code lookup.
`default_nettype none

module nhe_front
    import nhe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [2:0] cfg_wdata,
    input  wire logic       req_type,
    input  wire logic [7:0] symbol_char,
    output nhe_item_t       item
);

    logic [2:0] bits_reg [4];
    logic [1:0] len_reg  [4];
    logic [1:0] slot;
    logic       valid_char;
    logic [2:0] mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg[0] <= 3'd0; len_reg[0] <= 2'd2;
            bits_reg[1] <= 3'd1; len_reg[1] <= 2'd2;
            bits_reg[2] <= 3'd2; len_reg[2] <= 2'd2;
            bits_reg[3] <= 3'd3; len_reg[3] <= 2'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BITS_A: bits_reg[0] <= cfg_wdata;
                REG_LEN_A:  len_reg[0]  <= cfg_wdata[1:0];
                REG_BITS_C: bits_reg[1] <= cfg_wdata;
                REG_LEN_C:  len_reg[1]  <= cfg_wdata[1:0];
                REG_BITS_G: bits_reg[2] <= cfg_wdata;
                REG_LEN_G:  len_reg[2]  <= cfg_wdata[1:0];
                REG_BITS_T: bits_reg[3] <= cfg_wdata;
                REG_LEN_T:  len_reg[3]  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        valid_char = 1'b1;
        slot       = 2'd0;
        unique case (symbol_char)
            8'h41, 8'h61: slot = 2'd0;
            8'h43, 8'h63: slot = 2'd1;
            8'h47, 8'h67: slot = 2'd2;
            8'h54, 8'h74: slot = 2'd3;
            default:      valid_char = 1'b0;
        endcase
    end

    // Code bits above the length are masked off here.
    assign mask = 3'((4'd1 << len_reg[slot]) - 4'd1);

    always_comb begin
        item.len  = len_reg[slot];
        item.code = bits_reg[slot] & mask;
        if (req_type == REQ_FLUSH) begin
            item.kind = KIND_FLUSH;
        end else if (valid_char) begin
            item.kind = KIND_SYM;
        end else begin
            item.kind = KIND_BAD;
        end
    end

endmodule

`default_nettype wire

/* src/nhe_queue.sv */
// Two-entry queue that decouples the classifying front from the packing back.
`default_nettype none

module nhe_queue
    import nhe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  nhe_item_t push_item,
    output logic      not_full,
    input  wire logic pop,
    output logic      not_empty,
    output nhe_item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nhe_item_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* src/nhe_back.sv */
// Back end: bit accumulator, byte packing, flush sequence and output register.
`default_nettype none

module nhe_back
    import nhe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  nhe_item_t       q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_bad
);

    logic [6:0]  pend_bits_reg, pend_bits_next;
    logic [2:0]  pend_cnt_reg,  pend_cnt_next;
    logic        phase_reg,     phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_last_reg,  out_last_next;
    logic        out_bad_reg,   out_bad_next;

    logic        can_load;
    logic        load;
    logic [3:0]  sum;
    logic [9:0]  acc;
    logic [2:0]  rest;
    logic [9:0]  rest_mask;
    logic [2:0]  pad;
    logic [14:0] padded;

    assign can_load = !out_valid_reg || out_ready;
    assign sum      = {1'b0, pend_cnt_reg} + {2'b00, q_item.len};
    assign acc      = ({3'b000, pend_bits_reg} << q_item.len) | {7'b0, q_item.code};
    assign rest     = sum[2:0];
    assign rest_mask = (10'd1 << rest) - 10'd1;
    // Eight minus the count; an empty accumulator wraps to a pad of zero.
    assign pad      = 3'(4'd8 - {1'b0, pend_cnt_reg});
    assign padded   = {8'b0, pend_bits_reg} << pad;

    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        phase_next     = phase_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        load           = 1'b0;
        q_pop          = 1'b0;
        if (q_valid) begin
            unique case (q_item.kind)
                KIND_SYM: begin
                    if (sum[3]) begin
                        if (can_load) begin
                            load           = 1'b1;
                            q_pop          = 1'b1;
                            out_byte_next  = 8'(acc >> rest);
                            out_last_next  = 1'b0;
                            out_bad_next   = 1'b0;
                            pend_bits_next = 7'(acc & rest_mask);
                            pend_cnt_next  = rest;
                        end
                    end else begin
                        q_pop          = 1'b1;
                        pend_bits_next = acc[6:0];
                        pend_cnt_next  = sum[2:0];
                    end
                end
                KIND_BAD: begin
                    if (can_load) begin
                        load          = 1'b1;
                        q_pop         = 1'b1;
                        out_byte_next = 8'd0;
                        out_last_next = 1'b0;
                        out_bad_next  = 1'b1;
                    end
                end
                KIND_FLUSH: begin
                    if (can_load) begin
                        load         = 1'b1;
                        out_bad_next = 1'b0;
                        if (pend_cnt_reg != 3'd0 && !phase_reg) begin
                            out_byte_next = padded[7:0];
                            out_last_next = 1'b0;
                            phase_next    = 1'b1;
                        end else begin
                            out_byte_next  = {5'b0, pad};
                            out_last_next  = 1'b1;
                            q_pop          = 1'b1;
                            phase_next     = 1'b0;
                            pend_bits_next = 7'd0;
                            pend_cnt_next  = 3'd0;
                        end
                    end
                end
                default: begin
                    q_pop = 1'b1;
                end
            endcase
        end
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= 7'd0;
            pend_cnt_reg  <= 3'd0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

endmodule

`default_nettype wire

/* src/nhe_checker.sv */
// Port-level checker for the nucleotide Huffman encoder and its bind.
`default_nettype none

module nhe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // A trailer carries a padding count of at most seven and is never an error.
    a_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:3] == 5'd0 && !m_tuser)
        else $error("trailer beat malformed");

    // An error beat carries a zero byte and never ends the stream.
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 8'd0 && !m_tlast)
        else $error("error beat malformed");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind nucleotide_huffman_encoder nhe_checker u_nhe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/sv/tb_nucleotide_huffman_encoder.sv */
// Self-checking testbench for the nucleotide Huffman encoder with bit packer.
`timescale 1ns / 1ps
`default_nettype none

module tb_nucleotide_huffman_encoder;
    import nhe_pkg::*;

    // One output beat as the encoder should present it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       bad_symbol;
    } coded_beat_t;

    // The eight accepted characters; the slot of a character is its index modulo four.
    localparam logic [7:0] NT_CHARS [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
    localparam logic [2:0] BITS_REG [4] = '{REG_BITS_A, REG_BITS_C, REG_BITS_G, REG_BITS_T};
    localparam logic [2:0] LEN_REG  [4] = '{REG_LEN_A, REG_LEN_C, REG_LEN_G, REG_LEN_T};
    localparam int         SETTLE_CYCLES = 4;   // settling margin after the latency
    localparam int         RANDOM_PHASES = 8;
    localparam int         PHASE_ITEMS   = 212;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_index = 3'd0;
    logic [2:0] cfg_wdata = 3'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;
    logic       s_tuser   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Predictor state: the loaded code table and the bits still waiting for a full byte.
    logic [2:0]  code_bits [4];
    logic [1:0]  code_len  [4];
    logic [6:0]  acc_bits;
    logic [2:0]  acc_count;
    coded_beat_t expected_beats [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int error_count   = 0;

    nucleotide_huffman_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // The receiver stalls at random; the percentage is changed from phase to phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Works out the beats that one accepted input beat should produce and queues them.
    function automatic void encode_char(input logic req, input logic [7:0] ch);
        int          slot;
        int          rest;
        logic [1:0]  len;
        logic [2:0]  code;
        logic [9:0]  acc;
        logic [3:0]  total;
        logic [3:0]  pad;
        logic [14:0] padded;
        slot = -1;
        if (req == REQ_FLUSH) begin
            // The character travelling with a flush is ignored.
            pad = 4'd0;
            if (acc_count != 3'd0) begin
                pad = 4'd8 - {1'b0, acc_count};
                padded = {8'd0, acc_bits} << pad;
                expected_beats.push_back('{padded[7:0], 1'b0, 1'b0});
            end
            expected_beats.push_back('{{4'd0, pad}, 1'b1, 1'b0});
            acc_bits  = 7'd0;
            acc_count = 3'd0;
            return;
        end
        for (int i = 0; i < 8; i++) begin
            if (ch == NT_CHARS[i]) slot = i % 4;
        end
        if (slot < 0) begin
            // Not a nucleotide: an error beat, and the accumulator is left alone.
            expected_beats.push_back('{8'd0, 1'b0, 1'b1});
            return;
        end
        len   = code_len[slot];
        code  = code_bits[slot] & 3'((1 << len) - 1);
        acc   = ({3'd0, acc_bits} << len) | {7'd0, code};
        total = {1'b0, acc_count} + {2'd0, len};
        if (total >= 4'd8) begin
            rest = total - 8;
            expected_beats.push_back('{8'(acc >> rest), 1'b0, 1'b0});
            acc_bits  = 7'(acc & 10'((1 << rest) - 1));
            acc_count = 3'(rest);
        end else begin
            acc_bits  = acc[6:0];
            acc_count = total[2:0];
        end
    endfunction

    // Offers one beat on the input side, after a random idle gap, and waits for the handshake.
    // tvalid is left high afterwards so that back-to-back beats need no extra edge.
    task automatic send_char(input logic req, input logic [7:0] ch);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_char(req, ch);
    endtask

    // Stops sending and waits until every expected beat has come out, plus the latency.
    task automatic wait_encoder_idle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Loads all eight code registers. Length writes may carry a stray top bit, which the
    // block is expected to drop.
    task automatic load_codes(input logic [11:0] bits_all, input logic [7:0] lens_all);
        wait_encoder_idle();
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= BITS_REG[i];
            cfg_wdata <= bits_all[3*i +: 3];
            @(posedge aclk);
            code_bits[i] = bits_all[3*i +: 3];
            cfg_index <= LEN_REG[i];
            cfg_wdata <= {1'($urandom_range(0, 1)), lens_all[2*i +: 2]};
            @(posedge aclk);
            code_len[i] = lens_all[2*i +: 2];
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++) send_char(REQ_SYMBOL, text[i]);
    endtask

    // Reset codes: two bits each, full bytes from four symbols, both cases of letters, and a
    // flush with nothing pending as well as one with a partial byte.
    task automatic test_default_codes();
        send_string("ACGT");
        send_string("acgt");
        send_char(REQ_FLUSH, 8'h00);
        send_string("G");
        send_char(REQ_FLUSH, "T");
    endtask

    // Characters outside the nucleotide set, at both ends of the byte range and next to the
    // letters, including one in the middle of a partial byte.
    task automatic test_bad_symbols();
        send_char(REQ_SYMBOL, 8'h00);
        send_char(REQ_SYMBOL, 8'hFF);
        send_string("Bz");
        send_string("C");
        send_char(REQ_SYMBOL, 8'h80);
        send_char(REQ_FLUSH, 8'hFF);
    endtask

    // One-bit code with spare high bits, a zero-length code, and three-bit codes of all ones
    // and all zeros, so that a byte straddles two symbols.
    task automatic test_code_extremes();
        load_codes({3'd0, 3'd7, 3'd7, 3'd7}, {2'd3, 2'd3, 2'd0, 2'd1});
        send_string("ACGTg");
        send_char(REQ_FLUSH, "A");
    endtask

    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 99) < 92) return NT_CHARS[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Random phases, each with its own code table and idling mode. Most of the traffic is
    // streams of symbols closed by a flush; the rest is unframed noise.
    task automatic test_random_streams();
        int          sent;
        int          run_len;
        logic [11:0] bits_all;
        logic [7:0]  lens_all;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin bits_all = 12'hFFF; lens_all = 8'hFF; end
                2:       begin bits_all = 12'hFFF; lens_all = 8'h00; end
                4:       begin bits_all = 12'h000; lens_all = 8'hFF; end
                6:       begin bits_all = 12'($urandom()); lens_all = 8'h55; end
                default: begin bits_all = 12'($urandom()); lens_all = 8'($urandom()); end
            endcase
            load_codes(bits_all, lens_all);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
                default: begin src_idle_pct = 35; snk_stall_pct = 35; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    run_len = $urandom_range(0, 24);
                    for (int i = 0; i < run_len; i++) send_char(REQ_SYMBOL, random_char());
                    send_char(REQ_FLUSH, 8'($urandom_range(0, 255)));
                    sent += run_len + 1;
                end else begin
                    run_len = $urandom_range(1, 6);
                    for (int i = 0; i < run_len; i++) begin
                        send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    end
                    sent += run_len;
                end
            end
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    // Every output beat is matched against the oldest expectation, field by field.
    always @(posedge aclk) begin
        coded_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("%0t: unexpected beat data=%02h last=%b bad=%b",
                             $realtime, m_tdata, m_tlast, m_tuser);
                end
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.out_byte || m_tlast !== want.is_last ||
                    m_tuser !== want.bad_symbol) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: beat mismatch: expected data=%02h last=%b bad=%b, got data=%02h last=%b bad=%b",
                                 $realtime, want.out_byte, want.is_last, want.bad_symbol,
                                 m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial begin
        // Reset defaults of the code table: A=00, C=01, G=10, T=11.
        for (int i = 0; i < 4; i++) begin
            code_bits[i] = 3'(i);
            code_len[i]  = 2'd2;
        end
        acc_bits  = 7'd0;
        acc_count = 3'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_codes();
        test_bad_symbols();
        test_code_extremes();
        test_random_streams();

        wait_encoder_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_nucleotide_huffman_encoder OK");
        end else begin
            $display("tb_nucleotide_huffman_encoder NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4ms;
        $display("tb_nucleotide_huffman_encoder NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/nhe_pkg.sv
src/nhe_front.sv
src/nhe_queue.sv
src/nhe_back.sv
src/nucleotide_huffman_encoder.sv
src/nhe_checker.sv
tb/sv/tb_nucleotide_huffman_encoder.sv
